// File: rtl/dsg_pkg.sv
// Shared types and constants for the drive safety gate and motor mix block.
`default_nettype none
package dsg_pkg;

    typedef enum logic [1:0] {
        OP_DRIVE     = 2'd0,
        OP_KEEPALIVE = 2'd1,
        OP_TICK      = 2'd2,
        OP_UNUSED    = 2'd3
    } t_op;

    typedef enum logic {
        CFG_DEADMAN = 1'b0,
        CFG_CUTOFF  = 1'b1
    } t_cfg_idx;

    localparam int unsigned DEADMAN_W = 16;
    localparam int unsigned MV_W      = 13;
    localparam int unsigned PCT_W     = 8;
    localparam int unsigned CHARGE_W  = 7;

    localparam logic [DEADMAN_W-1:0] DEADMAN_RESET = 16'd500;
    localparam logic [MV_W-1:0]      CUTOFF_RESET  = 13'd3200;

endpackage
`default_nettype wire

// File: rtl/dsg_mix.sv
// X mix with clamping of the four motors, and battery charge percent.
`default_nettype none
module dsg_mix (
    input  wire logic signed [dsg_pkg::PCT_W-1:0]  i_fwd,
    input  wire logic signed [dsg_pkg::PCT_W-1:0]  i_lat,
    input  wire logic signed [dsg_pkg::PCT_W-1:0]  i_rot,
    input  wire logic [dsg_pkg::MV_W-1:0]          i_battery_mv,
    output logic signed [dsg_pkg::PCT_W-1:0]       o_motor_a,
    output logic signed [dsg_pkg::PCT_W-1:0]       o_motor_b,
    output logic signed [dsg_pkg::PCT_W-1:0]       o_motor_c,
    output logic signed [dsg_pkg::PCT_W-1:0]       o_motor_d,
    output logic [dsg_pkg::CHARGE_W-1:0]           o_charge_pct
);
    import dsg_pkg::*;

    localparam int SUM_W = PCT_W + 2;
    localparam logic signed [SUM_W-1:0] LIMIT_P = 10'sd100;
    localparam logic signed [SUM_W-1:0] LIMIT_N = -10'sd100;
    localparam logic [MV_W-1:0] EMPTY_MV = 13'd3300;
    localparam logic [MV_W-1:0] SPAN_MV  = 13'd850;
    // floor(d*100/850) = floor(2d/17); 2/17 ~ 7712 / 2^16, exact for d < 850
    localparam logic [13:0] RECIP = 14'd7712;

    function automatic logic signed [PCT_W-1:0] clamp_pct(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        begin
            c = v;
            if (v > LIMIT_P) c = LIMIT_P;
            if (v < LIMIT_N) c = LIMIT_N;
            clamp_pct = c[PCT_W-1:0];
        end
    endfunction

    logic signed [SUM_W-1:0] f, l, r;
    logic [MV_W-1:0]         d;
    logic [23:0]             prod;

    assign f = {{2{i_fwd[PCT_W-1]}}, i_fwd};
    assign l = {{2{i_lat[PCT_W-1]}}, i_lat};
    assign r = {{2{i_rot[PCT_W-1]}}, i_rot};

    assign o_motor_a = clamp_pct(f + l + r);
    assign o_motor_b = clamp_pct(f - l - r);
    assign o_motor_c = clamp_pct(f - l + r);
    assign o_motor_d = clamp_pct(f + l - r);

    assign d    = i_battery_mv - EMPTY_MV;
    assign prod = {14'd0, d[9:0]} * {10'd0, RECIP};

    always_comb begin
        if (i_battery_mv <= EMPTY_MV) begin
            o_charge_pct = '0;
        end else if (d >= SPAN_MV) begin
            o_charge_pct = 7'd100;
        end else begin
            o_charge_pct = prod[22:16];
        end
    end

endmodule
`default_nettype wire

// File: rtl/drive_safety_gate_and_motor_mix_top.sv
// Top level: drive safety gate with deadman, battery cutoff and four-motor X mix.
// A tick beat is taken into the input register, and its result is then loaded into the result register.
// Throughput: one beat per cycle; drive, keepalive and unused beats give no result.
// A tick waits in the input register only while the result register is full and stalled.
// Reset (synchronous, active low) clears valids, stored commands and command time,
// and loads the register defaults (deadman 500 ms, cutoff 3200 mV).
`default_nettype none
module drive_safety_gate_and_motor_mix_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: time_ms[31:0], fwd_pct[39:32], lat_pct[47:40], rot_pct[55:48],
    //        battery_mv[68:56], usb_present[69], fault_pending[70], pad[71]
    input  wire logic [71:0] s_axis_tdata,
    // tuser: operation[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: motor_a[7:0], motor_b[15:8], motor_c[23:16], motor_d[31:24],
    //        clear_faults[32], deadman_tripped[33], cutoff_active[34],
    //        charge_pct[41:35], pad[47:42]
    output logic [47:0]      m_axis_tdata
);
    import dsg_pkg::*;

    // config
    logic [DEADMAN_W-1:0] r_deadman;
    logic [MV_W-1:0]      r_cutoff;

    // input register
    logic        r_s1_valid;
    t_op         r_s1_op;
    logic [71:0] r_s1_data;

    // state
    logic signed [PCT_W-1:0] r_fwd, r_lat, r_rot;
    logic [31:0]             r_cmd_time;

    // result register
    logic        r_out_valid;
    logic [47:0] r_out_data;

    logic [31:0]             s1_time;
    logic signed [PCT_W-1:0] s1_fwd, s1_lat, s1_rot;
    logic [MV_W-1:0]         s1_mv;
    logic                    s1_usb, s1_fault;
    logic                    is_tick, out_free, s1_go;
    logic [31:0]             age;
    logic                    any_nz, trip, cut;
    logic signed [PCT_W-1:0] mix_f, mix_l, mix_r;
    logic signed [PCT_W-1:0] mot_a, mot_b, mot_c, mot_d;
    logic [CHARGE_W-1:0]     charge;

    assign s1_time  = r_s1_data[31:0];
    assign s1_fwd   = r_s1_data[39:32];
    assign s1_lat   = r_s1_data[47:40];
    assign s1_rot   = r_s1_data[55:48];
    assign s1_mv    = r_s1_data[68:56];
    assign s1_usb   = r_s1_data[69];
    assign s1_fault = r_s1_data[70];

    assign is_tick  = (r_s1_op == OP_TICK);
    assign out_free = !r_out_valid || m_axis_tready;
    assign s1_go    = r_s1_valid && (!is_tick || out_free);
    assign s_axis_tready = !r_s1_valid || s1_go;

    assign age    = s1_time - r_cmd_time;
    assign any_nz = (r_fwd != '0) || (r_lat != '0) || (r_rot != '0);
    assign trip   = (age > {16'd0, r_deadman}) && any_nz;
    assign cut    = (s1_mv < r_cutoff) && !s1_usb;

    // deadman clears and cutoff zeroes both give an all-zero mix
    assign mix_f = (trip || cut) ? '0 : r_fwd;
    assign mix_l = (trip || cut) ? '0 : r_lat;
    assign mix_r = (trip || cut) ? '0 : r_rot;

    dsg_mix u_mix (
        .i_fwd        (mix_f),
        .i_lat        (mix_l),
        .i_rot        (mix_r),
        .i_battery_mv (s1_mv),
        .o_motor_a    (mot_a),
        .o_motor_b    (mot_b),
        .o_motor_c    (mot_c),
        .o_motor_d    (mot_d),
        .o_charge_pct (charge)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadman <= DEADMAN_RESET;
            r_cutoff  <= CUTOFF_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DEADMAN: r_deadman <= i_cfg_data;
                CFG_CUTOFF:  r_cutoff  <= i_cfg_data[MV_W-1:0];
                default:     r_cutoff  <= r_cutoff;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_op   <= t_op'(s_axis_tuser);
            r_s1_data <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd      <= '0;
            r_lat      <= '0;
            r_rot      <= '0;
            r_cmd_time <= '0;
        end else if (s1_go) begin
            case (r_s1_op)
                OP_DRIVE: begin
                    r_fwd      <= s1_fwd;
                    r_lat      <= s1_lat;
                    r_rot      <= s1_rot;
                    r_cmd_time <= s1_time;
                end
                OP_KEEPALIVE: begin
                    r_cmd_time <= s1_time;
                end
                OP_TICK: begin
                    if (trip) begin
                        r_fwd <= '0;
                        r_lat <= '0;
                        r_rot <= '0;
                    end
                end
                default: begin
                    r_cmd_time <= r_cmd_time;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_go && is_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && is_tick) begin
            r_out_data <= {6'd0, charge, cut, trip, s1_fault, mot_d, mot_c, mot_b, mot_a};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_tick_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && is_tick) |=> m_axis_tvalid)
        else $error("accepted tick did not produce a result beat");

    a_trip_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && is_tick && trip) |=> (r_fwd == '0 && r_lat == '0 && r_rot == '0))
        else $error("deadman trip left stored commands");

    a_cutoff_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[34]) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("cutoff beat with nonzero motor duty");

    a_charge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[41:35] <= 7'd100))
        else $error("charge percent above 100");
`endif

endmodule
`default_nettype wire

// File: verif/drive_safety_gate_and_motor_mix_top_tb.sv
// Self-checking testbench for the drive safety gate and four-motor mix block.
`default_nettype none
module drive_safety_gate_and_motor_mix_top_tb;
    import dsg_pkg::*;

    localparam int DUTY_MAX     = 100;
    localparam int CHG_EMPTY_MV = 3300;
    localparam int CHG_SPAN_MV  = 850;
    localparam int PHASE_ITEMS  = 133;

    typedef struct packed {
        t_op               op;
        logic [31:0]       t_ms;
        logic signed [7:0] fwd;
        logic signed [7:0] lat;
        logic signed [7:0] rot;
        logic [12:0]       mv;
        logic              usb;
        logic              fault;
    } t_gate_beat;

    typedef struct packed {
        logic signed [7:0] motor_a;
        logic signed [7:0] motor_b;
        logic signed [7:0] motor_c;
        logic signed [7:0] motor_d;
        logic              clear_faults;
        logic              deadman_tripped;
        logic              cutoff_active;
        logic [6:0]        charge_pct;
    } t_mix_result;

    typedef struct packed {
        t_gate_beat  beat;
        logic        typed;
        t_mix_result want;
    } t_dir_row;

    localparam t_mix_result NO_CHECK = '0;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_idx     = 1'b0;
    logic [15:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    drive_safety_gate_and_motor_mix_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Gate state mirror
    logic signed [7:0] cmd_fwd = '0;
    logic signed [7:0] cmd_lat = '0;
    logic signed [7:0] cmd_rot = '0;
    logic [31:0]       cmd_time = '0;
    logic [15:0]       deadman_lim = DEADMAN_RESET;
    logic [12:0]       cutoff_lim  = CUTOFF_RESET;

    t_mix_result mix_q[$];
    t_dir_row    dir_rows[$];
    int          mismatch_cnt = 0;
    int          send_idle_pct = 24;
    int          recv_idle_pct = 77;
    int          hold_cycles = 0;
    logic [31:0] now_ms = '0;

    function automatic logic [7:0] clamp_pct(input int v);
        if (v > DUTY_MAX) v = DUTY_MAX;
        if (v < -DUTY_MAX) v = -DUTY_MAX;
        return 8'(v);
    endfunction

    // Applies one beat to the mirrored state; returns 1 when a tick result is due.
    function automatic bit step_gate(input t_gate_beat b, output t_mix_result res);
        int          f, l, r, chg;
        logic [31:0] age;
        logic        trip, cut;
        res = '0;
        case (b.op)
            OP_DRIVE: begin
                cmd_fwd = b.fwd;
                cmd_lat = b.lat;
                cmd_rot = b.rot;
                cmd_time = b.t_ms;
                return 1'b0;
            end
            OP_KEEPALIVE: begin
                cmd_time = b.t_ms;
                return 1'b0;
            end
            OP_TICK: begin
                age = b.t_ms - cmd_time;
                trip = (age > {16'd0, deadman_lim}) &&
                       (cmd_fwd != 0 || cmd_lat != 0 || cmd_rot != 0);
                if (trip) begin
                    cmd_fwd = '0;
                    cmd_lat = '0;
                    cmd_rot = '0;
                end
                // low battery zeroes this tick only, stored commands survive
                cut = (b.mv < cutoff_lim) && !b.usb;
                f = cut ? 0 : int'(cmd_fwd);
                l = cut ? 0 : int'(cmd_lat);
                r = cut ? 0 : int'(cmd_rot);
                res.motor_a = clamp_pct(f + l + r);
                res.motor_b = clamp_pct(f - l - r);
                res.motor_c = clamp_pct(f - l + r);
                res.motor_d = clamp_pct(f + l - r);
                res.clear_faults = b.fault;
                res.deadman_tripped = trip;
                res.cutoff_active = cut;
                if (int'(b.mv) <= CHG_EMPTY_MV) chg = 0;
                else chg = (int'(b.mv) - CHG_EMPTY_MV) * 100 / CHG_SPAN_MV;
                if (chg > 100) chg = 100;
                res.charge_pct = 7'(chg);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_gate_beat mk_beat(input t_op op, input logic [31:0] t_ms,
                                           input int f, input int l, input int r,
                                           input int mv, input bit usb, input bit fault);
        t_gate_beat b;
        b.op = op;
        b.t_ms = t_ms;
        b.fwd = 8'(f);
        b.lat = 8'(l);
        b.rot = 8'(r);
        b.mv = 13'(mv);
        b.usb = usb;
        b.fault = fault;
        return b;
    endfunction

    function automatic t_mix_result mk_mix(input int a, input int b, input int c, input int d,
                                           input bit clr, input bit trip, input bit cut,
                                           input int chg);
        t_mix_result m;
        m.motor_a = 8'(a);
        m.motor_b = 8'(b);
        m.motor_c = 8'(c);
        m.motor_d = 8'(d);
        m.clear_faults = clr;
        m.deadman_tripped = trip;
        m.cutoff_active = cut;
        m.charge_pct = 7'(chg);
        return m;
    endfunction

    function automatic logic [7:0] rand_pct();
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        return 8'($urandom_range(0, 200) - 100);
    endfunction

    function automatic t_gate_beat rand_beat();
        t_gate_beat b;
        int         pick, m;
        pick = $urandom_range(0, 99);
        if (pick < 35) b.op = OP_DRIVE;
        else if (pick < 50) b.op = OP_KEEPALIVE;
        else if (pick < 95) b.op = OP_TICK;
        else b.op = OP_UNUSED;
        // keep ages mostly near the deadman window so both outcomes show up
        case ($urandom_range(0, 19))
            0: now_ms = $urandom;
            1: now_ms = cmd_time + {16'd0, deadman_lim} + $urandom_range(0, 1);
            default: now_ms = now_ms + $urandom_range(0, int'(deadman_lim) * 3 / 4 + 2);
        endcase
        b.t_ms = now_ms;
        b.fwd = rand_pct();
        b.lat = rand_pct();
        b.rot = rand_pct();
        case ($urandom_range(0, 5))
            0: m = int'(cutoff_lim) - 1 + int'($urandom_range(0, 2));
            1: m = CHG_EMPTY_MV - 1 + int'($urandom_range(0, 2));
            2: m = CHG_EMPTY_MV + CHG_SPAN_MV - 1 + int'($urandom_range(0, 2));
            default: m = $urandom_range(0, 5000);
        endcase
        if (m < 0) m = 0;
        if (m > 5000) m = 5000;
        b.mv = 13'(m);
        b.usb = ($urandom_range(0, 3) == 0);
        b.fault = 1'($urandom_range(0, 1));
        return b;
    endfunction

    task automatic send_beat(input t_gate_beat b, input bit typed, input t_mix_result want);
        t_mix_result res;
        // each idle cycle is drawn on its own
        if ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            while ($urandom_range(0, 99) < send_idle_pct) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, b.fault, b.usb, b.mv, b.rot, b.lat, b.fwd, b.t_ms};
        s_axis_tuser <= b.op;
        do @(posedge i_clk); while (!s_axis_tready);
        if (step_gate(b, res)) mix_q.push_back(typed ? want : res);
    endtask

    // Lower valid and let every outstanding tick result come back.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (mix_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] dm, input logic [12:0] co);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_DEADMAN;
        i_cfg_data <= dm;
        @(negedge i_clk);
        i_cfg_idx <= CFG_CUTOFF;
        i_cfg_data <= {3'd0, co};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        deadman_lim = dm;
        cutoff_lim = co;
    endtask

    // Result side: random backpressure, with an occasional long hold-off.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : mix_check
        t_mix_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.motor_a = m_axis_tdata[7:0];
            got.motor_b = m_axis_tdata[15:8];
            got.motor_c = m_axis_tdata[23:16];
            got.motor_d = m_axis_tdata[31:24];
            got.clear_faults = m_axis_tdata[32];
            got.deadman_tripped = m_axis_tdata[33];
            got.cutoff_active = m_axis_tdata[34];
            got.charge_pct = m_axis_tdata[41:35];
            if (mix_q.size() == 0) begin
                mismatch_cnt = mismatch_cnt + 1;
                if (mismatch_cnt <= 10)
                    $display("unexpected result beat: a=%0d b=%0d c=%0d d=%0d",
                             $signed(got.motor_a), $signed(got.motor_b),
                             $signed(got.motor_c), $signed(got.motor_d));
            end else begin
                want = mix_q.pop_front();
                if (got.motor_a !== want.motor_a || got.motor_b !== want.motor_b ||
                    got.motor_c !== want.motor_c || got.motor_d !== want.motor_d ||
                    got.clear_faults !== want.clear_faults ||
                    got.deadman_tripped !== want.deadman_tripped ||
                    got.cutoff_active !== want.cutoff_active ||
                    got.charge_pct !== want.charge_pct) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= 10) begin
                        $display("exp a=%0d b=%0d c=%0d d=%0d clr=%0b trip=%0b cut=%0b chg=%0d",
                                 $signed(want.motor_a), $signed(want.motor_b),
                                 $signed(want.motor_c), $signed(want.motor_d),
                                 want.clear_faults, want.deadman_tripped,
                                 want.cutoff_active, want.charge_pct);
                        $display("got a=%0d b=%0d c=%0d d=%0d clr=%0b trip=%0b cut=%0b chg=%0d",
                                 $signed(got.motor_a), $signed(got.motor_b),
                                 $signed(got.motor_c), $signed(got.motor_d),
                                 got.clear_faults, got.deadman_tripped,
                                 got.cutoff_active, got.charge_pct);
                    end
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("drive_safety_gate_and_motor_mix_top: mismatch");
        $finish;
    end

    initial begin
        int          ph, cnt;
        t_gate_beat  b;
        t_dir_row    row;

        // deadman 500 ms, cutoff 3200 mV after reset
        dir_rows.push_back('{mk_beat(OP_TICK, 32'd0, 0, 0, 0, 0, 0, 0), 1'b1,
                             mk_mix(0, 0, 0, 0, 0, 0, 1, 0)});
        dir_rows.push_back('{mk_beat(OP_TICK, 32'd100, 0, 0, 0, 5000, 0, 1), 1'b1,
                             mk_mix(0, 0, 0, 0, 1, 0, 0, 100)});
        dir_rows.push_back('{mk_beat(OP_DRIVE, 32'd1000, 100, 0, 0, 0, 0, 0), 1'b0, NO_CHECK});
        dir_rows.push_back('{mk_beat(OP_TICK, 32'd1200, 0, 0, 0, 4150, 0, 0), 1'b1,
                             mk_mix(100, 100, 100, 100, 0, 0, 0, 100)});
        dir_rows.push_back('{mk_beat(OP_DRIVE, 32'd1300, 100, 100, 100, 0, 0, 0), 1'b0,
                             NO_CHECK});
        dir_rows.push_back('{mk_beat(OP_TICK, 32'd1500, 0, 0, 0, 3725, 0, 0), 1'b1,
                             mk_mix(100, -100, 100, 100, 0, 0, 0, 50)});
        // commands beyond +-100 are kept as given and clamped after the sum
        dir_rows.push_back('{mk_beat(OP_DRIVE, 32'd2000, -128, -128, -128, 0, 0, 0), 1'b0,
                             NO_CHECK});
        dir_rows.push_back('{mk_beat(OP_TICK, 32'd2000, 0, 0, 0, 3300, 0, 0), 1'b1,
                             mk_mix(-100, 100, -100, -100, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_beat(OP_DRIVE, 32'd2100, 127, -128, 0, 0, 0, 0), 1'b0,
                             NO_CHECK});
        dir_rows.push_back('{mk_beat(OP_TICK, 32'd2150, 0, 0, 0, 3301, 1, 0), 1'b0, NO_CHECK});
        dir_rows.push_back('{mk_beat(OP_TICK, 32'd2200, 0, 0, 0, 3199, 0, 0), 1'b1,
                             mk_mix(0, 0, 0, 0, 0, 0, 1, 0)});
        dir_rows.push_back('{mk_beat(OP_TICK, 32'd2300, 0, 0, 0, 3200, 0, 0), 1'b0, NO_CHECK});
        // age 501 trips the deadman
        dir_rows.push_back('{mk_beat(OP_TICK, 32'd2601, 0, 0, 0, 4000, 0, 1), 1'b1,
                             mk_mix(0, 0, 0, 0, 1, 1, 0, 82)});
        dir_rows.push_back('{mk_beat(OP_TICK, 32'd2700, 0, 0, 0, 4000, 0, 0), 1'b0, NO_CHECK});
        dir_rows.push_back('{mk_beat(OP_DRIVE, 32'd3000, 10, 20, 30, 0, 0, 0), 1'b0, NO_CHECK});
        dir_rows.push_back('{mk_beat(OP_KEEPALIVE, 32'd3400, 99, 99, 99, 5000, 1, 1), 1'b0,
                             NO_CHECK});
        dir_rows.push_back('{mk_beat(OP_TICK, 32'd3900, 0, 0, 0, 4149, 0, 0), 1'b0, NO_CHECK});
        dir_rows.push_back('{mk_beat(OP_UNUSED, 32'd0, -1, -1, -1, 8191, 1, 1), 1'b0,
                             NO_CHECK});
        dir_rows.push_back('{mk_beat(OP_TICK, 32'd3950, 0, 0, 0, 4150, 1, 1), 1'b0, NO_CHECK});
        // command age across the 32-bit wrap
        dir_rows.push_back('{mk_beat(OP_DRIVE, 32'hFFFF_FF00, 50, -50, 0, 0, 0, 0), 1'b0,
                             NO_CHECK});
        dir_rows.push_back('{mk_beat(OP_TICK, 32'h0000_0100, 0, 0, 0, 3400, 0, 0), 1'b1,
                             mk_mix(0, 0, 0, 0, 0, 1, 0, 11)});
        dir_rows.push_back('{mk_beat(OP_DRIVE, 32'hFFFF_FFF0, -100, 100, -100, 0, 0, 0), 1'b0,
                             NO_CHECK});
        dir_rows.push_back('{mk_beat(OP_TICK, 32'h0000_0010, 0, 0, 0, 5000, 0, 0), 1'b0,
                             NO_CHECK});
        dir_rows.push_back('{mk_beat(OP_TICK, 32'h0000_0010, 0, 0, 0, 0, 1, 0), 1'b0,
                             NO_CHECK});

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_beat(row.beat, row.typed, row.want);
        end
        now_ms = 32'h0000_0010;

        for (ph = 0; ph < 6; ph++) begin
            drain_results();
            case (ph)
                0: ;
                1: write_regs(16'd0, 13'd0);
                2: write_regs(16'hFFFF, 13'd5000);
                3: write_regs(16'($urandom_range(1, 2000)), 13'($urandom_range(2800, 4200)));
                4: write_regs(16'd1, 13'd4150);
                default: write_regs(16'($urandom), 13'($urandom_range(0, 5000)));
            endcase
            if (ph < 2) begin
                send_idle_pct = 24;
                recv_idle_pct = 77;
            end else if (ph < 4) begin
                send_idle_pct = 77;
                recv_idle_pct = 24;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 2) now_ms = 32'hFFFF_0000 + $urandom_range(0, 32'hFFFF);
            cnt = 0;
            while (cnt < PHASE_ITEMS) begin
                if (ph == 0 && cnt == 60) drain_results();
                // long result stall while ticks keep coming
                if (ph == 4 && cnt == 30) hold_cycles = 300;
                b = rand_beat();
                send_beat(b, 1'b0, NO_CHECK);
                if (b.op != OP_UNUSED) cnt++;
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && mix_q.size() == 0)
            $display("drive_safety_gate_and_motor_mix_top: match");
        else
            $display("drive_safety_gate_and_motor_mix_top: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
